### rtl/kbl_pkg.sv
package kbl_pkg;

	localparam int LINE_PIXELS = 320;
	localparam int SCALE_STEP  = 3;
	localparam int PHASE_W     = $clog2(SCALE_STEP + 1);

	localparam int PIX_W   = 8;
	localparam int ADDR_W  = 16;
	localparam int X_W     = 9;
	localparam int Y_W     = 8;
	localparam int DIM_W   = 8;
	localparam int IDX_W   = 3;
	localparam int CDATA_W = 9;

	typedef enum logic [1:0] {
		MODE_COPY   = 2'd0,
		MODE_KEY    = 2'd1,
		MODE_FILL   = 2'd2,
		MODE_SCALED = 2'd3
	} mode_t;

	typedef enum logic [IDX_W-1:0] {
		REG_DEST_X        = 3'd0,
		REG_DEST_Y        = 3'd1,
		REG_SPRITE_WIDTH  = 3'd2,
		REG_SPRITE_HEIGHT = 3'd3,
		REG_BLIT_MODE     = 3'd4,
		REG_DRAW_COLOR    = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic [ADDR_W-1:0] start_addr;
		logic [DIM_W-1:0]  width;
		logic [DIM_W-1:0]  height;
		mode_t             mode;
		logic [PIX_W-1:0]  color;
	} cfg_t;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] addr;
		logic [PIX_W-1:0]  data;
		logic              last;
	} res_t;

	function automatic logic [ADDR_W-1:0] start_of(logic [Y_W-1:0] y, logic [X_W-1:0] x);
		return ADDR_W'(int'(y) * LINE_PIXELS + int'(x));
	endfunction

endpackage

### rtl/keyed_sprite_blitter.sv
// Colour-key sprite blitter. Sprite pixels enter one per cycle in row-major order; each
// gives one output word in the next cycle, through a single output register. A new pixel
// is taken every cycle while the output is free or being taken, so the rate is one pixel
// per clock. The user must write registers on the config port only while the stream is
// idle (the block does not enforce it); a write to a defined index restarts the sprite at
// its top-left pixel. Address: (dest_y+row)*320+dest_x+col mod 65536; mode 3 writes
// nonzero pixels of every third col and row at row/3, col/3. No clearing pass after reset.
module keyed_sprite_blitter (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_write,
	input  logic [kbl_pkg::IDX_W-1:0]     cfg_index,
	input  logic [kbl_pkg::CDATA_W-1:0]   cfg_data,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [7:0]                    s_tdata,  // pixel_value
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [31:0]                   m_tdata,  // write_enable, write_address, write_data
	output logic                          m_tlast   // last_pixel
);

	kbl_pkg::cfg_t cfg;
	kbl_pkg::res_t res, res_q;
	logic          clear, in_fire, out_valid_q;

	kbl_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg),
		.clear     (clear)
	);

	kbl_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.clear   (clear),
		.advance (in_fire),
		.pixel   (s_tdata),
		.res     (res)
	);

	assign s_tready = !out_valid_q || m_tready;
	assign in_fire  = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_fire) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			res_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'b0, res_q.data, res_q.addr, res_q.we};
	assign m_tlast  = res_q.last;

endmodule

### rtl/kbl_cfg.sv
module kbl_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_write,
	input  logic [kbl_pkg::IDX_W-1:0]     cfg_index,
	input  logic [kbl_pkg::CDATA_W-1:0]   cfg_data,
	output kbl_pkg::cfg_t                 cfg,
	output logic                          clear
);

	logic [kbl_pkg::X_W-1:0]    dest_x_q;
	logic [kbl_pkg::Y_W-1:0]    dest_y_q;
	logic [kbl_pkg::ADDR_W-1:0] start_q;
	logic [kbl_pkg::DIM_W-1:0]  width_q;
	logic [kbl_pkg::DIM_W-1:0]  height_q;
	kbl_pkg::mode_t             mode_q;
	logic [kbl_pkg::PIX_W-1:0]  color_q;
	logic                       idx_ok;

	always_comb begin
		unique case (cfg_index)
			kbl_pkg::REG_DEST_X, kbl_pkg::REG_DEST_Y, kbl_pkg::REG_SPRITE_WIDTH,
			kbl_pkg::REG_SPRITE_HEIGHT, kbl_pkg::REG_BLIT_MODE,
			kbl_pkg::REG_DRAW_COLOR: idx_ok = 1'b1;
			default:                 idx_ok = 1'b0;
		endcase
	end

	assign clear = cfg_write && idx_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dest_x_q <= '0;
			dest_y_q <= '0;
			start_q  <= '0;
			width_q  <= '0;
			height_q <= '0;
			mode_q   <= kbl_pkg::MODE_COPY;
			color_q  <= '0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				kbl_pkg::REG_DEST_X: begin
					dest_x_q <= cfg_data[kbl_pkg::X_W-1:0];
					start_q  <= kbl_pkg::start_of(dest_y_q, cfg_data[kbl_pkg::X_W-1:0]);
				end
				kbl_pkg::REG_DEST_Y: begin
					dest_y_q <= cfg_data[kbl_pkg::Y_W-1:0];
					start_q  <= kbl_pkg::start_of(cfg_data[kbl_pkg::Y_W-1:0], dest_x_q);
				end
				kbl_pkg::REG_SPRITE_WIDTH:  width_q  <= cfg_data[kbl_pkg::DIM_W-1:0];
				kbl_pkg::REG_SPRITE_HEIGHT: height_q <= cfg_data[kbl_pkg::DIM_W-1:0];
				kbl_pkg::REG_BLIT_MODE:     mode_q   <= kbl_pkg::mode_t'(cfg_data[1:0]);
				kbl_pkg::REG_DRAW_COLOR:    color_q  <= cfg_data[kbl_pkg::PIX_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg.start_addr = start_q;
	assign cfg.width      = width_q;
	assign cfg.height     = height_q;
	assign cfg.mode       = mode_q;
	assign cfg.color      = color_q;

endmodule

### rtl/kbl_core.sv
module kbl_core (
	input  logic                      clk,
	input  logic                      arst_n,
	input  kbl_pkg::cfg_t             cfg,
	input  logic                      clear,
	input  logic                      advance,
	input  logic [kbl_pkg::PIX_W-1:0] pixel,
	output kbl_pkg::res_t             res
);

	logic [kbl_pkg::DIM_W-1:0]   col_q, row_q;
	logic [kbl_pkg::ADDR_W-1:0]  base_q, offset_q;
	logic [kbl_pkg::PHASE_W-1:0] cphase_q, rphase_q;

	logic                        empty, at_start, row_end, last, col_wrap, row_wrap;
	logic                        we_raw;
	logic [kbl_pkg::ADDR_W-1:0]  base;
	logic [kbl_pkg::DIM_W:0]     col_inc, row_inc, rows;
	logic [kbl_pkg::PIX_W-1:0]   data_raw;

	assign empty    = (cfg.width == '0);
	assign at_start = (col_q == '0) && (row_q == '0);
	assign base     = at_start ? cfg.start_addr : base_q;
	assign col_inc  = {1'b0, col_q} + 1'b1;
	assign row_inc  = {1'b0, row_q} + 1'b1;
	assign rows     = (cfg.height == '0) ? (kbl_pkg::DIM_W+1)'(1) : {1'b0, cfg.height};
	assign row_end  = col_inc >= {1'b0, cfg.width};
	assign last     = row_end && (row_inc >= rows);
	assign col_wrap = (32'(cphase_q) + 1) >= kbl_pkg::SCALE_STEP;
	assign row_wrap = (32'(rphase_q) + 1) >= kbl_pkg::SCALE_STEP;

	always_comb begin
		unique case (cfg.mode)
			kbl_pkg::MODE_COPY: begin
				we_raw   = 1'b1;
				data_raw = pixel;
			end
			kbl_pkg::MODE_KEY: begin
				we_raw   = (pixel != '0);
				data_raw = pixel;
			end
			kbl_pkg::MODE_FILL: begin
				we_raw   = (pixel != '0);
				data_raw = cfg.color;
			end
			kbl_pkg::MODE_SCALED: begin
				we_raw   = (pixel != '0) && (cphase_q == '0) && (rphase_q == '0);
				data_raw = pixel;
			end
			default: begin
				we_raw   = 1'b0;
				data_raw = '0;
			end
		endcase
	end

	always_comb begin
		if (empty) begin
			res.we   = 1'b0;
			res.addr = cfg.start_addr;
			res.data = '0;
			res.last = 1'b1;
		end else begin
			res.we   = we_raw;
			res.addr = base + offset_q;
			res.data = we_raw ? data_raw : '0;
			res.last = last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q    <= '0;
			row_q    <= '0;
			base_q   <= '0;
			offset_q <= '0;
			cphase_q <= '0;
			rphase_q <= '0;
		end else if (clear || (advance && !empty && last)) begin
			col_q    <= '0;
			row_q    <= '0;
			base_q   <= '0;
			offset_q <= '0;
			cphase_q <= '0;
			rphase_q <= '0;
		end else if (advance && !empty) begin
			if (cfg.mode == kbl_pkg::MODE_SCALED) begin
				if (row_end) begin
					col_q    <= '0;
					row_q    <= row_inc[kbl_pkg::DIM_W-1:0];
					offset_q <= '0;
					cphase_q <= '0;
					if (row_wrap) begin
						rphase_q <= '0;
						base_q   <= base + kbl_pkg::ADDR_W'(kbl_pkg::LINE_PIXELS);
					end else begin
						rphase_q <= rphase_q + 1'b1;
						base_q   <= base;
					end
				end else begin
					col_q  <= col_inc[kbl_pkg::DIM_W-1:0];
					base_q <= base;
					if (col_wrap) begin
						cphase_q <= '0;
						offset_q <= offset_q + 1'b1;
					end else begin
						cphase_q <= cphase_q + 1'b1;
					end
				end
			end else begin
				if (row_end) begin
					col_q    <= '0;
					row_q    <= row_inc[kbl_pkg::DIM_W-1:0];
					offset_q <= '0;
					base_q   <= base + kbl_pkg::ADDR_W'(kbl_pkg::LINE_PIXELS);
				end else begin
					col_q    <= col_inc[kbl_pkg::DIM_W-1:0];
					offset_q <= offset_q + 1'b1;
					base_q   <= base;
				end
				cphase_q <= '0;
				rphase_q <= '0;
			end
		end
	end

endmodule
